>>> src/hrhp_pkg.sv
package hrhp_pkg;

	// Parser states, one-hot
	typedef enum logic [19:0] {
		PS_MSTART = 20'h00001,
		PS_METHOD = 20'h00002,
		PS_URI    = 20'h00004,
		PS_H      = 20'h00008,
		PS_T1     = 20'h00010,
		PS_T2     = 20'h00020,
		PS_P      = 20'h00040,
		PS_SLASH  = 20'h00080,
		PS_MAJ0   = 20'h00100,
		PS_MAJ    = 20'h00200,
		PS_MIN0   = 20'h00400,
		PS_MIN    = 20'h00800,
		PS_LF1    = 20'h01000,
		PS_LINE   = 20'h02000,
		PS_LWS    = 20'h04000,
		PS_NAME   = 20'h08000,
		PS_SP     = 20'h10000,
		PS_VALUE  = 20'h20000,
		PS_LF2    = 20'h40000,
		PS_LF3    = 20'h80000
	} parse_state_t;

	typedef enum logic [1:0] {
		STAT_MORE     = 2'd0,
		STAT_COMPLETE = 2'd1,
		STAT_ERROR    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_METHOD = 3'd1,
		KIND_URI    = 3'd2,
		KIND_NEWHDR = 3'd3,
		KIND_NAME   = 3'd4,
		KIND_VALUE  = 3'd5
	} byte_kind_t;

	localparam logic ACT_CONSUME = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_CTL_MAX = 8'd31;

	localparam logic [15:0] ACC_MAX = 16'hFFFF;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} hrhp_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  byte_kind;
		logic [7:0]  byte_out;
		logic [15:0] version_major;
		logic [15:0] version_minor;
	} hrhp_out_t;

	// Parser context carried from one byte to the next
	typedef struct packed {
		parse_state_t pstate;
		logic         has_header;
		logic [15:0]  major;
		logic [15:0]  minor;
	} hrhp_ctx_t;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= CH_CTL_MAX) || (c == CH_DEL);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		logic r;
		case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
			8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
			8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && !is_ctl(c) && !is_sep(c);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_lws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	// acc * 10 + digit, saturating at 16 bits
	function automatic logic [15:0] dec_push(input logic [15:0] acc, input logic [7:0] c);
		logic [19:0] v;
		logic [7:0]  d;
		d = c - CH_ZERO;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d[3:0]};
		return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[15:0];
	endfunction

endpackage

>>> src/hrhp_step.sv
module hrhp_step (
	input  hrhp_pkg::hrhp_in_t  req,
	input  hrhp_pkg::hrhp_ctx_t ctx,
	output hrhp_pkg::hrhp_ctx_t ctx_next,
	output hrhp_pkg::hrhp_out_t res
);
	import hrhp_pkg::*;

	logic [7:0]   c;
	status_t      status;
	byte_kind_t   kind;
	parse_state_t ns;
	logic         hh;
	logic [15:0]  maj;
	logic [15:0]  mnr;

	assign c = req.data_byte;

	always_comb begin
		status = STAT_MORE;
		kind   = KIND_NONE;
		ns     = ctx.pstate;
		hh     = ctx.has_header;
		maj    = ctx.major;
		mnr    = ctx.minor;
		if (req.action == ACT_RESTART) begin
			ns = PS_MSTART;
			hh = 1'b0;
		end else begin
			unique case (ctx.pstate)
				PS_MSTART: begin
					if (is_token(c)) begin
						ns   = PS_METHOD;
						kind = KIND_METHOD;
					end else status = STAT_ERROR;
				end
				PS_METHOD: begin
					if (c == CH_SPACE) ns = PS_URI;
					else if (is_token(c)) kind = KIND_METHOD;
					else status = STAT_ERROR;
				end
				PS_URI: begin
					if (c == CH_SPACE) ns = PS_H;
					else if (is_ctl(c)) status = STAT_ERROR;
					else kind = KIND_URI;
				end
				PS_H:  if (c == CH_H) ns = PS_T1; else status = STAT_ERROR;
				PS_T1: if (c == CH_T) ns = PS_T2; else status = STAT_ERROR;
				PS_T2: if (c == CH_T) ns = PS_P; else status = STAT_ERROR;
				PS_P:  if (c == CH_P) ns = PS_SLASH; else status = STAT_ERROR;
				PS_SLASH: begin
					if (c == CH_SLASH) begin
						maj = '0;
						mnr = '0;
						ns  = PS_MAJ0;
					end else status = STAT_ERROR;
				end
				PS_MAJ0: begin
					if (is_digit(c)) begin
						maj = dec_push(ctx.major, c);
						ns  = PS_MAJ;
					end else status = STAT_ERROR;
				end
				PS_MAJ: begin
					if (c == CH_DOT) ns = PS_MIN0;
					else if (is_digit(c)) maj = dec_push(ctx.major, c);
					else status = STAT_ERROR;
				end
				PS_MIN0: begin
					if (is_digit(c)) begin
						mnr = dec_push(ctx.minor, c);
						ns  = PS_MIN;
					end else status = STAT_ERROR;
				end
				PS_MIN: begin
					if (c == CH_CR) ns = PS_LF1;
					else if (is_digit(c)) mnr = dec_push(ctx.minor, c);
					else status = STAT_ERROR;
				end
				PS_LF1: if (c == CH_LF) ns = PS_LINE; else status = STAT_ERROR;
				PS_LINE: begin
					if (c == CH_CR) ns = PS_LF3;
					else if (ctx.has_header && is_lws(c)) ns = PS_LWS;
					else if (is_token(c)) begin
						hh   = 1'b1;
						kind = KIND_NEWHDR;
						ns   = PS_NAME;
					end else status = STAT_ERROR;
				end
				PS_LWS: begin
					if (c == CH_CR) ns = PS_LF2;
					else if (is_lws(c)) ns = PS_LWS;
					else if (is_ctl(c)) status = STAT_ERROR;
					else begin
						ns   = PS_VALUE;
						kind = KIND_VALUE;
					end
				end
				PS_NAME: begin
					if (c == CH_COLON) ns = PS_SP;
					else if (is_token(c)) kind = KIND_NAME;
					else status = STAT_ERROR;
				end
				PS_SP: if (c == CH_SPACE) ns = PS_VALUE; else status = STAT_ERROR;
				PS_VALUE: begin
					if (c == CH_CR) ns = PS_LF2;
					else if (is_ctl(c)) status = STAT_ERROR;
					else kind = KIND_VALUE;
				end
				PS_LF2: if (c == CH_LF) ns = PS_LINE; else status = STAT_ERROR;
				PS_LF3: status = (c == CH_LF) ? STAT_COMPLETE : STAT_ERROR;
				default: status = STAT_ERROR;
			endcase
			// a rejected byte leaves the context untouched
			if (status == STAT_ERROR) ns = ctx.pstate;
		end
	end

	assign ctx_next.pstate     = ns;
	assign ctx_next.has_header = hh;
	assign ctx_next.major      = maj;
	assign ctx_next.minor      = mnr;

	assign res.status        = status;
	assign res.byte_kind     = kind;
	assign res.byte_out      = (kind != KIND_NONE) ? c : 8'd0;
	assign res.version_major = maj;
	assign res.version_minor = mnr;

endmodule

>>> src/http_request_header_parser_top.sv
// Pipeline: an accepted request byte is held in the input register, and its result is
//   then loaded into the result register, which drives the result handshake.
// Throughput: one byte per cycle when res_stall is low; the only loop is the parser
//   context register (state, header flag, version accumulators), updated once per byte.
// Reset (arst_n low, asynchronous): parser back to method start, header flag and
//   version accumulators cleared, both pipeline stages empty.
module http_request_header_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hdr_valid,
	output logic                hdr_stall,
	input  hrhp_pkg::hrhp_in_t  hdr,
	output logic                res_valid,
	input  logic                res_stall,
	output hrhp_pkg::hrhp_out_t res
);
	import hrhp_pkg::*;

	// Stage 1: registered input request
	logic      vld_s1;
	hrhp_in_t  req_s1;

	// Stage 2: registered result
	logic      vld_s2;
	hrhp_out_t res_s2;

	// Parser context, advanced once per request leaving stage 1
	hrhp_ctx_t ctx_q;
	hrhp_ctx_t ctx_next;
	hrhp_out_t res_next;

	logic advance;
	logic take;

	// Stage 1 moves on whenever the result register is empty or being drained.
	assign advance   = vld_s1 && (!vld_s2 || !res_stall);
	assign hdr_stall = vld_s1 && !advance;
	assign take      = hdr_valid && !hdr_stall;

	hrhp_step u_step (
		.req      (req_s1),
		.ctx      (ctx_q),
		.ctx_next (ctx_next),
		.res      (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (!res_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	// Context commits exactly when its request's result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.pstate     <= PS_MSTART;
			ctx_q.has_header <= 1'b0;
			ctx_q.major      <= '0;
			ctx_q.minor      <= '0;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

// Byte-stream check of the HTTP request parser.
// The driver feeds request bytes from pending_bytes; at each accepted request the
// parser model below advances its own copy of the context and queues the expected
// result. The monitor pops one expectation per accepted result and compares fields.
module testbench;
	import hrhp_pkg::*;

	localparam int PHASE_ITEMS    = 550;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_MAX     = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      hdr_valid = 1'b0;
	logic      hdr_stall;
	hrhp_in_t  hdr       = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	hrhp_out_t res;

	http_request_header_parser_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_stall (hdr_stall),
		.hdr       (hdr),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	hrhp_in_t  pending_bytes[$];
	hrhp_out_t expected_results[$];

	// Idle rates in percent, and noise rate for the request generator
	int send_idle_pct = 20;
	int recv_idle_pct = 47;
	int noise_pct     = 0;
	int phase_items   = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	// Parser model context
	parse_state_t m_state;
	logic         m_has_header;
	logic [15:0]  m_major;
	logic [15:0]  m_minor;

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- character classes

	function automatic logic ctl_char(input logic [7:0] c);
		return (c <= CH_CTL_MAX) || (c == CH_DEL);
	endfunction

	// Token: 7-bit, no control, no separator (bytes >= 128 act as negative chars)
	function automatic logic token_char(input logic [7:0] c);
		logic sep;
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", CH_SPACE, CH_TAB: sep = 1'b1;
			default: sep = 1'b0;
		endcase
		return !c[7] && !ctl_char(c) && !sep;
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Decimal shift-in, saturating at 16 bits
	function automatic logic [15:0] dec_step(input logic [15:0] acc, input logic [7:0] c);
		int unsigned v;
		v = acc * 10 + c - CH_ZERO;
		return (v > ACC_MAX) ? ACC_MAX : v[15:0];
	endfunction

	// ---------------------------------------------------------------- parser model

	task automatic predict_byte(input hrhp_in_t req);
		hrhp_out_t    r;
		parse_state_t nxt;
		logic [7:0]   c;
		logic         err;
		c   = req.data_byte;
		nxt = m_state;
		err = 1'b0;
		r   = '0;
		r.status    = STAT_MORE;
		r.byte_kind = KIND_NONE;
		if (req.action == ACT_RESTART) begin
			// restart keeps the version accumulators
			m_state      = PS_MSTART;
			m_has_header = 1'b0;
		end else begin
			case (m_state)
				PS_MSTART: begin
					if (token_char(c)) begin
						nxt = PS_METHOD;
						r.byte_kind = KIND_METHOD;
					end else err = 1'b1;
				end
				PS_METHOD: begin
					if (c == CH_SPACE) nxt = PS_URI;
					else if (token_char(c)) r.byte_kind = KIND_METHOD;
					else err = 1'b1;
				end
				PS_URI: begin
					if (c == CH_SPACE) nxt = PS_H;
					else if (ctl_char(c)) err = 1'b1;
					else r.byte_kind = KIND_URI;
				end
				PS_H: if (c == CH_H) nxt = PS_T1; else err = 1'b1;
				PS_T1: if (c == CH_T) nxt = PS_T2; else err = 1'b1;
				PS_T2: if (c == CH_T) nxt = PS_P; else err = 1'b1;
				PS_P: if (c == CH_P) nxt = PS_SLASH; else err = 1'b1;
				PS_SLASH: begin
					if (c == CH_SLASH) begin
						m_major = '0;
						m_minor = '0;
						nxt = PS_MAJ0;
					end else err = 1'b1;
				end
				PS_MAJ0: begin
					if (digit_char(c)) begin
						m_major = dec_step(m_major, c);
						nxt = PS_MAJ;
					end else err = 1'b1;
				end
				PS_MAJ: begin
					if (c == CH_DOT) nxt = PS_MIN0;
					else if (digit_char(c)) m_major = dec_step(m_major, c);
					else err = 1'b1;
				end
				PS_MIN0: begin
					if (digit_char(c)) begin
						m_minor = dec_step(m_minor, c);
						nxt = PS_MIN;
					end else err = 1'b1;
				end
				PS_MIN: begin
					if (c == CH_CR) nxt = PS_LF1;
					else if (digit_char(c)) m_minor = dec_step(m_minor, c);
					else err = 1'b1;
				end
				PS_LF1: if (c == CH_LF) nxt = PS_LINE; else err = 1'b1;
				PS_LINE: begin
					if (c == CH_CR) nxt = PS_LF3;
					else if (m_has_header && (c == CH_SPACE || c == CH_TAB)) nxt = PS_LWS;
					else if (token_char(c)) begin
						m_has_header = 1'b1;
						r.byte_kind = KIND_NEWHDR;
						nxt = PS_NAME;
					end else err = 1'b1;
				end
				PS_LWS: begin
					if (c == CH_CR) nxt = PS_LF2;
					else if (c == CH_SPACE || c == CH_TAB) nxt = PS_LWS;
					else if (ctl_char(c)) err = 1'b1;
					else begin
						nxt = PS_VALUE;
						r.byte_kind = KIND_VALUE;
					end
				end
				PS_NAME: begin
					if (c == CH_COLON) nxt = PS_SP;
					else if (token_char(c)) r.byte_kind = KIND_NAME;
					else err = 1'b1;
				end
				PS_SP: if (c == CH_SPACE) nxt = PS_VALUE; else err = 1'b1;
				PS_VALUE: begin
					if (c == CH_CR) nxt = PS_LF2;
					else if (ctl_char(c)) err = 1'b1;
					else r.byte_kind = KIND_VALUE;
				end
				PS_LF2: if (c == CH_LF) nxt = PS_LINE; else err = 1'b1;
				// final CR seen: parser parks here until restart
				PS_LF3: if (c == CH_LF) r.status = STAT_COMPLETE; else err = 1'b1;
				default: err = 1'b1;
			endcase
			if (err) begin
				r.status    = STAT_ERROR;
				r.byte_kind = KIND_NONE;
			end else begin
				m_state = nxt;
			end
		end
		r.byte_out      = (r.byte_kind != KIND_NONE) ? c : 8'h00;
		r.version_major = m_major;
		r.version_minor = m_minor;
		expected_results.insert(expected_results.size(), r);
	endtask

	// ---------------------------------------------------------------- request generation

	task automatic push_req(input logic act, input logic [7:0] b);
		hrhp_in_t r;
		r.action    = act;
		r.data_byte = b;
		pending_bytes.insert(pending_bytes.size(), r);
		phase_items++;
	endtask

	// Consume byte, sometimes preceded by a stray byte
	task automatic push_char(input logic [7:0] b);
		if ($urandom_range(99) < noise_pct)
			push_req(ACT_CONSUME, 8'($urandom_range(255)));
		push_req(ACT_CONSUME, b);
	endtask

	task automatic push_text(input string s);
		foreach (s[i])
			push_char(s[i]);
	endtask

	function automatic logic [7:0] rand_token();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (!token_char(c));
		return c;
	endfunction

	// Non-control byte; space allowed only where asked (URI ends on space)
	function automatic logic [7:0] rand_text(input logic allow_space);
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (ctl_char(c) || (!allow_space && c == CH_SPACE));
		return c;
	endfunction

	task automatic push_digits();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
		repeat (n) push_char(8'(CH_ZERO + $urandom_range(9)));
	endtask

	// One well-formed request with random content (plus stray bytes when noise_pct > 0)
	task automatic gen_request();
		int n_hdr;
		int n_fold;
		push_req(ACT_RESTART, 8'($urandom_range(255)));
		repeat ($urandom_range(1, 8)) push_char(rand_token());
		push_char(CH_SPACE);
		repeat ($urandom_range(0, 12)) push_char(rand_text(1'b0));
		push_char(CH_SPACE);
		push_text("HTTP/");
		push_digits();
		push_char(CH_DOT);
		push_digits();
		push_char(CH_CR);
		push_char(CH_LF);
		n_hdr = $urandom_range(0, 4);
		repeat (n_hdr) begin
			repeat ($urandom_range(1, 8)) push_char(rand_token());
			push_char(CH_COLON);
			push_char(CH_SPACE);
			repeat ($urandom_range(0, 12)) push_char(rand_text(1'b1));
			push_char(CH_CR);
			push_char(CH_LF);
			n_fold = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
			repeat (n_fold) begin
				repeat ($urandom_range(1, 3)) push_char($urandom_range(1) ? CH_SPACE : CH_TAB);
				repeat ($urandom_range(0, 8)) push_char(rand_text(1'b1));
				push_char(CH_CR);
				push_char(CH_LF);
			end
		end
		push_char(CH_CR);
		push_char(CH_LF);
		// bytes after completion: LF repeats the completion, any other byte is rejected
		repeat ($urandom_range(0, 2))
			push_char($urandom_range(1) ? CH_LF : 8'($urandom_range(255)));
	endtask

	// Raw noise burst, restarts included
	task automatic gen_noise();
		repeat ($urandom_range(5, 20))
			push_req(($urandom_range(7) == 0) ? ACT_RESTART : ACT_CONSUME,
				8'($urandom_range(255)));
	endtask

	// Sender holds off until every queued request has been answered
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || hdr_valid || expected_results.size() != 0);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid <= 1'b0;
			hdr <= '0;
			m_state = PS_MSTART;
			m_has_header = 1'b0;
			m_major = '0;
			m_minor = '0;
		end else begin
			if (hdr_valid && !hdr_stall)
				predict_byte(hdr);
			// payload holds while stalled
			if (!hdr_valid || !hdr_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					hdr <= pending_bytes.pop_front();
					hdr_valid <= 1'b1;
				end else begin
					hdr_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		hrhp_out_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result with nothing pending: status %0d kind %0d byte %h",
							$realtime, res.status, res.byte_kind, res.byte_out);
				end else begin
					want = expected_results.pop_front();
					if (res.status !== want.status || res.byte_kind !== want.byte_kind ||
						res.byte_out !== want.byte_out ||
						res.version_major !== want.version_major ||
						res.version_minor !== want.version_minor) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$write("%0t: mismatch exp st %0d kind %0d byte %h maj %0d min %0d",
								$realtime, want.status, want.byte_kind, want.byte_out,
								want.version_major, want.version_minor);
							$display(" / got st %0d kind %0d byte %h maj %0d min %0d",
								res.status, res.byte_kind, res.byte_out,
								res.version_major, res.version_minor);
						end
					end
				end
			end
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if ((hdr_valid && !hdr_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin
		// Directed: byte extremes, rejects, overflow, fold before any header,
		// empty value, fold, wrong byte after final CR, repeated completion.
		push_req(ACT_RESTART, 8'hFF);
		push_req(ACT_CONSUME, "G");
		push_req(ACT_CONSUME, 8'h00);
		push_req(ACT_CONSUME, CH_SPACE);
		push_req(ACT_CONSUME, 8'hFF);
		push_req(ACT_CONSUME, CH_SPACE);
		push_text("HTTP/99999.0");
		push_req(ACT_CONSUME, CH_CR);
		push_req(ACT_CONSUME, CH_LF);
		push_req(ACT_CONSUME, CH_SPACE);
		push_text("k: ");
		push_req(ACT_CONSUME, CH_CR);
		push_req(ACT_CONSUME, CH_LF);
		push_req(ACT_CONSUME, CH_TAB);
		push_req(ACT_CONSUME, CH_CR);
		push_req(ACT_CONSUME, CH_LF);
		push_req(ACT_CONSUME, CH_CR);
		push_req(ACT_CONSUME, "x");
		push_req(ACT_CONSUME, CH_LF);
		push_req(ACT_CONSUME, CH_LF);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		// Random: three idle profiles, each drained before the next
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 20; recv_idle_pct = 47; end
				1: begin send_idle_pct = 47; recv_idle_pct = 20; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				noise_pct = ($urandom_range(3) == 0) ? 4 : 0;
				if ($urandom_range(9) == 0)
					gen_noise();
				else
					gen_request();
			end
			wait_drained();
		end

		// two-stage pipeline: let any stray result surface
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
src/hrhp_pkg.sv
src/hrhp_step.sv
src/http_request_header_parser_top.sv
bench/testbench.sv
